// ===== src/lrd_pkg.sv =====
package lrd_pkg;

  localparam int ADDR_W    = 16;
  localparam int VAL_W     = 17;
  localparam int TREE_N    = 65536;
  localparam int MAX_BINS  = 64;
  localparam int BIN_W     = 6;
  localparam int NB_W      = 7;
  localparam int J_W       = 18;
  localparam int DVD_W     = 33;
  localparam int REM_W     = 18;
  localparam int DCNT_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [VAL_W-1:0]  DATASET_RST = 17'd65536;
  localparam logic [NB_W-1:0]   BUCKETS_RST = 7'd64;
  localparam logic [VAL_W-1:0]  WIDTH_RST   = 17'd1024;
  localparam logic [DCNT_W-1:0] DIV_STEPS   = 6'd33;

  localparam logic [CFG_IDX_W-1:0] REG_DATASET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKETS = 1'b1;

  localparam logic [1:0] KIND_DIST  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_OVF   = 2'd3;

  localparam logic [1:0] DIV_WIDTH  = 2'd0;
  localparam logic [1:0] DIV_BUCKET = 2'd1;
  localparam logic [1:0] DIV_RATIO  = 2'd2;

  localparam logic [1:0] J_TOTAL  = 2'd0;
  localparam logic [1:0] J_P1     = 2'd1;
  localparam logic [1:0] J_TOTAL1 = 2'd2;

  typedef struct packed {
    logic       clr_step;
    logic       load_in;
    logic       seen_rd;
    logic       p_load;
    logic       j_init;
    logic [1:0] j_sel;
    logic       acc_clr;
    logic       delta_neg;
    logic       tree_rd;
    logic       tree_acc;
    logic       tree_sub;
    logic       tree_wr;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_step;
    logic       bw_load;
    logic       clr_dirty;
    logic       dist_load;
    logic       dist_cold;
    logic       hist_rd;
    logic       hist_wr;
    logic       hist_bin;
    logic       seen_wr;
    logic       total_inc;
    logic       ro_init;
    logic       ro_acc;
    logic       ro_next;
    logic       out_load;
    logic [1:0] out_kind;
  } lrd_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic dirty;
    logic mode;
    logic seen_hit;
    logic full;
    logic empty;
    logic j_zero;
    logic j_over;
    logic div_done;
    logic out_free;
    logic fin;
  } lrd_stat_t;

endpackage

// ===== src/lrd_in_if.sv =====
interface lrd_in_if import lrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, mode, address, input ready);
  modport sink (input valid, mode, address, output ready);
endinterface

// ===== src/lrd_out_if.sv =====
interface lrd_out_if import lrd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [VAL_W-1:0] distance;
  logic             cold;
  logic [VAL_W-1:0] cache_size;
  logic [VAL_W-1:0] miss_count;
  logic [VAL_W-1:0] miss_ratio;
  logic             last;

  modport source (output valid, kind, distance, cold, cache_size, miss_count, miss_ratio,
                  last, input ready);
  modport sink (input valid, kind, distance, cold, cache_size, miss_count, miss_ratio,
                last, output ready);
endinterface

// ===== src/lrd_ctrl.sv =====
module lrd_ctrl import lrd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      in_ready,
  input  lrd_stat_t stat,
  output lrd_cmd_t  cmd
);

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_WDIV    = 5'd2;
  localparam logic [4:0] S_DECODE  = 5'd3;
  localparam logic [4:0] S_SEEN    = 5'd4;
  localparam logic [4:0] S_QRD     = 5'd5;
  localparam logic [4:0] S_QACC    = 5'd6;
  localparam logic [4:0] S_BDIV    = 5'd7;
  localparam logic [4:0] S_HWR     = 5'd8;
  localparam logic [4:0] S_URD     = 5'd9;
  localparam logic [4:0] S_UWR     = 5'd10;
  localparam logic [4:0] S_ODIST   = 5'd11;
  localparam logic [4:0] S_OEMPTY  = 5'd12;
  localparam logic [4:0] S_OOVF    = 5'd13;
  localparam logic [4:0] S_RORD    = 5'd14;
  localparam logic [4:0] S_ROACC   = 5'd15;
  localparam logic [4:0] S_ROSTART = 5'd16;
  localparam logic [4:0] S_RODIV   = 5'd17;
  localparam logic [4:0] S_ROOUT   = 5'd18;

  localparam logic [1:0] PH_Q1 = 2'd0;
  localparam logic [1:0] PH_Q2 = 2'd1;
  localparam logic [1:0] PH_U1 = 2'd2;
  localparam logic [1:0] PH_U2 = 2'd3;

  logic [4:0] state, state_next;
  logic [1:0] phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= PH_Q1;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !stat.dirty;

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (stat.dirty) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_WIDTH;
          cmd.clr_dirty = 1'b1;
          state_next    = S_WDIV;
        end else if (item_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_WDIV: begin
        if (stat.div_done) begin
          cmd.bw_load = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DECODE: begin
        if (stat.mode) begin
          if (stat.empty) begin
            state_next = S_OEMPTY;
          end else begin
            cmd.ro_init = 1'b1;
            state_next  = S_RORD;
          end
        end else if (stat.full) begin
          state_next = S_OOVF;
        end else begin
          cmd.seen_rd = 1'b1;
          state_next  = S_SEEN;
        end
      end
      S_SEEN: begin
        cmd.p_load = 1'b1;
        cmd.j_init = 1'b1;
        if (stat.seen_hit) begin
          cmd.j_sel   = J_TOTAL;
          cmd.acc_clr = 1'b1;
          phase_next  = PH_Q1;
          state_next  = S_QRD;
        end else begin
          cmd.j_sel     = J_TOTAL1;
          cmd.dist_cold = 1'b1;
          phase_next    = PH_U2;
          state_next    = S_URD;
        end
      end
      S_QRD: begin
        if (stat.j_zero) begin
          if (phase == PH_Q1) begin
            cmd.j_init = 1'b1;
            cmd.j_sel  = J_P1;
            phase_next = PH_Q2;
          end else begin
            cmd.dist_load = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_BUCKET;
            state_next    = S_BDIV;
          end
        end else begin
          cmd.tree_rd = 1'b1;
          state_next  = S_QACC;
        end
      end
      S_QACC: begin
        cmd.tree_acc = 1'b1;
        cmd.tree_sub = (phase == PH_Q2);
        state_next   = S_QRD;
      end
      S_BDIV: begin
        if (stat.div_done) begin
          cmd.hist_rd = 1'b1;
          state_next  = S_HWR;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_HWR: begin
        cmd.hist_wr   = 1'b1;
        cmd.j_init    = 1'b1;
        cmd.j_sel     = J_P1;
        cmd.delta_neg = 1'b1;
        phase_next    = PH_U1;
        state_next    = S_URD;
      end
      S_URD: begin
        if (stat.j_over) begin
          if (phase == PH_U1) begin
            cmd.j_init = 1'b1;
            cmd.j_sel  = J_TOTAL1;
            phase_next = PH_U2;
          end else begin
            cmd.seen_wr   = 1'b1;
            cmd.total_inc = 1'b1;
            state_next    = S_ODIST;
          end
        end else begin
          cmd.tree_rd = 1'b1;
          state_next  = S_UWR;
        end
      end
      S_UWR: begin
        cmd.tree_wr = 1'b1;
        state_next  = S_URD;
      end
      S_ODIST: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_DIST;
          state_next   = S_IDLE;
        end
      end
      S_OEMPTY: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_EMPTY;
          state_next   = S_IDLE;
        end
      end
      S_OOVF: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_OVF;
          state_next   = S_IDLE;
        end
      end
      S_RORD: begin
        cmd.hist_rd  = 1'b1;
        cmd.hist_bin = 1'b1;
        state_next   = S_ROACC;
      end
      S_ROACC: begin
        cmd.ro_acc = 1'b1;
        state_next = S_ROSTART;
      end
      S_ROSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATIO;
        state_next    = S_RODIV;
      end
      S_RODIV: begin
        if (stat.div_done) begin
          state_next = S_ROOUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_ROOUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_POINT;
          if (stat.fin) begin
            state_next = S_IDLE;
          end else begin
            cmd.ro_next = 1'b1;
            state_next  = S_RORD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/lrd_dp.sv =====
module lrd_dp import lrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 item_mode,
  input  logic [ADDR_W-1:0]    item_address,
  lrd_out_if.source            result,
  input  lrd_cmd_t             cmd,
  output lrd_stat_t            stat
);

  logic [VAL_W-1:0]  dataset_size;
  logic [NB_W-1:0]   bucket_count;
  logic              dirty;
  logic [VAL_W-1:0]  bucket_width;
  logic [VAL_W-1:0]  access_total;
  logic              mode_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] p_r;
  logic [J_W-1:0]    j;
  logic [VAL_W-1:0]  acc;
  logic              delta_neg;
  logic [DVD_W-1:0]  dvd;
  logic [REM_W-1:0]  rem;
  logic [VAL_W-1:0]  dsr;
  logic [DCNT_W-1:0] dcnt;
  logic [VAL_W-1:0]  dist_r;
  logic              cold_r;
  logic [BIN_W-1:0]  b;
  logic [VAL_W-1:0]  hit;
  logic [VAL_W-1:0]  cb;
  logic [VAL_W-1:0]  miss;

  logic              out_valid;
  logic [1:0]        out_kind;
  logic [VAL_W-1:0]  out_distance;
  logic              out_cold;
  logic [VAL_W-1:0]  out_cache;
  logic [VAL_W-1:0]  out_miss;
  logic [VAL_W-1:0]  out_ratio;
  logic              out_last;

  logic [VAL_W-1:0]  eff_ds;
  logic [NB_W-1:0]   eff_nb;
  logic [BIN_W-1:0]  nb_top;
  logic [J_W-1:0]    lowbit;
  logic [J_W-1:0]    jm1;
  logic [BIN_W-1:0]  bin_idx;
  logic              fin;
  logic              out_free;

  assign eff_ds = (dataset_size == '0) ? VAL_W'(1) : dataset_size;
  always_comb begin
    if (bucket_count == '0) begin
      eff_nb = NB_W'(1);
    end else if (bucket_count > NB_W'(MAX_BINS)) begin
      eff_nb = NB_W'(MAX_BINS);
    end else begin
      eff_nb = bucket_count;
    end
  end
  assign nb_top = BIN_W'(eff_nb - NB_W'(1));

  // Configuration registers; any write marks the bin width for recomputation.
  always_ff @(posedge clk) begin
    if (rst) begin
      dataset_size <= DATASET_RST;
      bucket_count <= BUCKETS_RST;
      dirty        <= 1'b1;
    end else begin
      if (cmd.clr_dirty) dirty <= 1'b0;
      if (cfg_we) begin
        dirty <= 1'b1;
        case (cfg_index)
          REG_DATASET: dataset_size <= cfg_data;
          REG_BUCKETS: bucket_count <= cfg_data[NB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Last-seen table: bit 16 is the valid flag, the rest the access position.
  logic [VAL_W-1:0]  seen_mem [TREE_N];
  logic [VAL_W-1:0]  seen_q;
  logic [ADDR_W-1:0] seen_addr;
  assign seen_addr = cmd.clr_step ? clr_cnt : addr_r;
  always_ff @(posedge clk) begin
    if (cmd.clr_step || cmd.seen_wr) begin
      seen_mem[seen_addr] <= cmd.clr_step ? '0 : {1'b1, access_total[ADDR_W-1:0]};
    end
    if (cmd.seen_rd) seen_q <= seen_mem[seen_addr];
  end

  // Fenwick tree over access positions; node j lives at address j-1.
  logic [VAL_W-1:0]  tree_mem [TREE_N];
  logic [VAL_W-1:0]  tree_q;
  logic [ADDR_W-1:0] tree_addr;
  assign jm1       = j - J_W'(1);
  assign tree_addr = cmd.clr_step ? clr_cnt : jm1[ADDR_W-1:0];
  assign lowbit    = j & (~j + J_W'(1));
  always_ff @(posedge clk) begin
    if (cmd.clr_step || cmd.tree_wr) begin
      tree_mem[tree_addr] <= cmd.clr_step ? '0 :
                             (tree_q + (delta_neg ? {VAL_W{1'b1}} : VAL_W'(1)));
    end
    if (cmd.tree_rd) tree_q <= tree_mem[tree_addr];
  end

  // Distance histogram.
  logic [VAL_W-1:0] hist_mem [MAX_BINS];
  logic [VAL_W-1:0] hist_q;
  logic [BIN_W-1:0] hist_addr;
  logic             hist_we;
  assign bin_idx = (dvd[VAL_W-1:0] >= VAL_W'(eff_nb)) ? nb_top : dvd[BIN_W-1:0];
  always_comb begin
    if (cmd.clr_step) begin
      hist_addr = clr_cnt[BIN_W-1:0];
    end else if (cmd.hist_bin) begin
      hist_addr = b;
    end else begin
      hist_addr = bin_idx;
    end
  end
  assign hist_we = (cmd.clr_step && (clr_cnt[ADDR_W-1:BIN_W] == '0)) || cmd.hist_wr;
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_addr] <= cmd.clr_step ? '0 : hist_q + VAL_W'(1);
    if (cmd.hist_rd) hist_q <= hist_mem[hist_addr];
  end

  // Restoring divider, one quotient bit per cycle.
  logic [REM_W-1:0] rem_sh;
  logic             rem_ge;
  assign rem_sh = {rem[REM_W-2:0], dvd[DVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dcnt <= DIV_STEPS;
      rem  <= '0;
      case (cmd.div_sel)
        DIV_WIDTH: begin
          dvd <= DVD_W'(eff_ds) + DVD_W'(eff_nb) - DVD_W'(1);
          dsr <= VAL_W'(eff_nb);
        end
        DIV_BUCKET: begin
          dvd <= DVD_W'(acc);
          dsr <= bucket_width;
        end
        default: begin
          dvd <= {miss, 16'd0};
          dsr <= access_total;
        end
      endcase
    end else if (cmd.div_step) begin
      dcnt <= dcnt - DCNT_W'(1);
      rem  <= rem_ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
      dvd  <= {dvd[DVD_W-2:0], rem_ge};
    end
  end

  logic [VAL_W:0]   cb_sum;
  logic [VAL_W-1:0] hit_n;
  assign cb_sum = {1'b0, cb} + {1'b0, bucket_width};
  assign hit_n  = hit + hist_q;
  assign fin    = (cb == eff_ds) || ((NB_W'(b) + NB_W'(1)) == eff_nb);

  always_ff @(posedge clk) begin
    if (rst) begin
      access_total <= '0;
      bucket_width <= WIDTH_RST;
      clr_cnt      <= '0;
    end else begin
      if (cmd.total_inc) access_total <= access_total + VAL_W'(1);
      if (cmd.bw_load) bucket_width <= dvd[VAL_W-1:0];
      if (cmd.clr_step) clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= item_mode;
      addr_r <= item_address;
    end
    if (cmd.p_load) p_r <= seen_q[ADDR_W-1:0];
    if (cmd.j_init) begin
      delta_neg <= cmd.delta_neg;
      case (cmd.j_sel)
        J_TOTAL: j <= J_W'(access_total);
        J_P1:    j <= J_W'(p_r) + J_W'(1);
        default: j <= J_W'(access_total) + J_W'(1);
      endcase
    end else if (cmd.tree_acc) begin
      j <= j - lowbit;
    end else if (cmd.tree_wr) begin
      j <= j + lowbit;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.tree_acc) begin
      acc <= cmd.tree_sub ? (acc - tree_q) : (acc + tree_q);
    end
    if (cmd.dist_load) begin
      dist_r <= acc + VAL_W'(1);
      cold_r <= 1'b0;
    end else if (cmd.dist_cold) begin
      dist_r <= '0;
      cold_r <= 1'b1;
    end
    if (cmd.ro_init) begin
      b   <= '0;
      hit <= '0;
      cb  <= '0;
    end else if (cmd.ro_acc) begin
      hit  <= hit_n;
      cb   <= (cb_sum > {1'b0, eff_ds}) ? eff_ds : cb_sum[VAL_W-1:0];
      miss <= (hit_n > access_total) ? '0 : (access_total - hit_n);
    end else if (cmd.ro_next) begin
      b <= b + BIN_W'(1);
    end
  end

  // Output register.
  assign out_free = !out_valid || result.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind     <= cmd.out_kind;
      out_distance <= (cmd.out_kind == KIND_DIST) ? dist_r : '0;
      out_cold     <= (cmd.out_kind == KIND_DIST) ? cold_r : 1'b0;
      out_cache    <= (cmd.out_kind == KIND_POINT) ? cb : '0;
      out_miss     <= (cmd.out_kind == KIND_POINT) ? miss : '0;
      out_ratio    <= (cmd.out_kind == KIND_POINT) ? dvd[VAL_W-1:0] : '0;
      out_last     <= (cmd.out_kind == KIND_POINT) ? fin : 1'b1;
    end
  end

  assign result.valid      = out_valid;
  assign result.kind       = out_kind;
  assign result.distance   = out_distance;
  assign result.cold       = out_cold;
  assign result.cache_size = out_cache;
  assign result.miss_count = out_miss;
  assign result.miss_ratio = out_ratio;
  assign result.last       = out_last;

  assign stat.clr_done = (clr_cnt == {ADDR_W{1'b1}});
  assign stat.dirty    = dirty;
  assign stat.mode     = mode_r;
  assign stat.seen_hit = seen_q[VAL_W-1];
  assign stat.full     = (access_total >= VAL_W'(TREE_N));
  assign stat.empty    = (access_total == '0);
  assign stat.j_zero   = (j == '0);
  assign stat.j_over   = (j > J_W'(TREE_N));
  assign stat.div_done = (dcnt == '0);
  assign stat.out_free = out_free;
  assign stat.fin      = fin;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register loaded while a beat is pending");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    cmd.total_inc |=> (access_total == $past(access_total) + VAL_W'(1)))
    else $error("access count did not advance by one");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (dcnt != '0))
    else $error("divider stepped after finishing");

endmodule

// ===== src/lru_reuse_distance_mrc.sv =====
// Channel   Dir  Payload                                              Handshake
// item      in   mode, address                                        valid/ready
// result    out  kind, distance, cold, cache_size, miss_count,        valid/ready
//                miss_ratio, last
// config    in   cfg_index, cfg_data                                  cfg_we
//
// After reset a clearing pass zeroes the last-seen table, the Fenwick tree and
// the histogram; no item beat is taken until it ends.
// An access makes up to two prefix walks of up to 16 steps and two update walks
// of up to 17, each step a tree read and then an accumulate or a write back on
// the single tree memory port, plus a divide for the bin.
// A readout emits each curve point after a bin read, an accumulate and a divide.
// A configuration write brings a bin width divide before the next beat is taken.
// Reset is synchronous; a stalled result holds in the output register.
module lru_reuse_distance_mrc import lrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  lrd_in_if.sink               item,
  lrd_out_if.source            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  // The controller sequences each beat; the datapath holds every store.
  lrd_cmd_t  cmd;
  lrd_stat_t stat;
  logic      in_ready;

  assign item.ready = in_ready;

  lrd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lrd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_mode    (item.mode),
    .item_address (item.address),
    .result       (result),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
